/* design/best_fit_page_allocator_top_defines.svh */
// Assertion macros for the allocator's top level.
`ifndef BEST_FIT_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define BFPA_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a cause is followed by an effect in the next cycle.
`define BFPA_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) else $error(msg);

`endif

/* design/bfpa_pkg.sv */
// Shared types and constants of the best-fit page allocator.
package bfpa_pkg;

  localparam logic [31:0] HEAP_BASE_RESET = 32'h8000_0000;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } bfpa_kind_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_NO_FIT    = 3'd1,
    STATUS_NOT_ALLOC = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_ZERO      = 3'd4
  } bfpa_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIT_SCAN,
    ST_FIT_CHECK,
    ST_USED_SCAN,
    ST_USED_CHECK,
    ST_HOLE_SCAN,
    ST_HOLE_CHECK,
    ST_UPDATE,
    ST_RESP
  } bfpa_state_e;

  typedef struct packed {
    bfpa_kind_e   kind;
    logic [29:0]  request_bytes;
    logic [31:0]  release_address;
  } bfpa_req_t;

  typedef struct packed {
    bfpa_status_e status;
    logic [31:0]  granted_address;
    logic [17:0]  page_count;
  } bfpa_rsp_t;

endpackage

/* design/bfpa_cell.sv */
// One extent slot of a rotating table: valid flag, start page and length.
module bfpa_cell #(
  parameter int unsigned     SW        = 17,
  parameter int unsigned     LW        = 18,
  parameter bit              RST_VALID = 1'b0,
  parameter logic [LW-1:0]   RST_LEN   = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          valid_i,
  input  logic [SW-1:0] start_i,
  input  logic [LW-1:0] len_i,
  output logic          valid_o,
  output logic [SW-1:0] start_o,
  output logic [LW-1:0] len_o
);

  logic          valid_q;
  logic [SW-1:0] start_q;
  logic [LW-1:0] len_q;

  // The slot takes its neighbor's contents whenever the table rotates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= RST_VALID;
      start_q <= '0;
      len_q   <= RST_LEN;
    end else if (shift_i) begin
      valid_q <= valid_i;
      start_q <= start_i;
      len_q   <= len_i;
    end
  end

  assign valid_o = valid_q;
  assign start_o = start_q;
  assign len_o   = len_q;

endmodule

/* design/bfpa_chain.sv */
// Row of extent cells that rotates one slot per cycle toward its tail while shift is high.
module bfpa_chain #(
  parameter int unsigned   DEPTH      = 64,
  parameter int unsigned   SW         = 17,
  parameter int unsigned   LW         = 18,
  parameter bit            TAIL_VALID = 1'b0,
  parameter logic [LW-1:0] TAIL_LEN   = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          valid_i,
  input  logic [SW-1:0] start_i,
  input  logic [LW-1:0] len_i,
  output logic          tail_valid_o,
  output logic [SW-1:0] tail_start_o,
  output logic [LW-1:0] tail_len_o,
  output logic          nxt_valid_o,
  output logic [SW-1:0] nxt_start_o,
  output logic [LW-1:0] nxt_len_o
);

  logic          cell_v [DEPTH];
  logic [SW-1:0] cell_s [DEPTH];
  logic [LW-1:0] cell_l [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      bfpa_cell #(.SW(SW), .LW(LW), .RST_VALID(1'b0), .RST_LEN('0)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift_i),
        .valid_i (valid_i),
        .start_i (start_i),
        .len_i   (len_i),
        .valid_o (cell_v[k]),
        .start_o (cell_s[k]),
        .len_o   (cell_l[k])
      );
    end else if (k == DEPTH - 1) begin : g_tail
      // The tail cell holds table entry zero after reset.
      bfpa_cell #(.SW(SW), .LW(LW), .RST_VALID(TAIL_VALID), .RST_LEN(TAIL_LEN)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift_i),
        .valid_i (cell_v[k-1]),
        .start_i (cell_s[k-1]),
        .len_i   (cell_l[k-1]),
        .valid_o (cell_v[k]),
        .start_o (cell_s[k]),
        .len_o   (cell_l[k])
      );
    end else begin : g_mid
      bfpa_cell #(.SW(SW), .LW(LW), .RST_VALID(1'b0), .RST_LEN('0)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift_i),
        .valid_i (cell_v[k-1]),
        .start_i (cell_s[k-1]),
        .len_i   (cell_l[k-1]),
        .valid_o (cell_v[k]),
        .start_o (cell_s[k]),
        .len_o   (cell_l[k])
      );
    end
  end

  assign tail_valid_o = cell_v[DEPTH-1];
  assign tail_start_o = cell_s[DEPTH-1];
  assign tail_len_o   = cell_l[DEPTH-1];
  assign nxt_valid_o  = cell_v[DEPTH-2];
  assign nxt_start_o  = cell_s[DEPTH-2];
  assign nxt_len_o    = cell_l[DEPTH-2];

endmodule

/* design/best_fit_page_allocator_top.sv */
// Top level of the best-fit page allocator with a coalescing free table.
//
// The allocator keeps two tables of extents, each a ring of MAX_EXTENTS cells
// that rotates by one cell per cycle while a pass is in progress: the free
// table, sorted by start page, and the table of live allocations. All compare,
// merge, insert and delete work happens in one small unit at the tail of each
// ring, so every pass over a table is one full turn and the ring comes back
// to its original alignment at the end. An allocate transaction takes one
// pass to find the best fit, a decision state and an update pass before its
// result is loaded. A free transaction takes a lookup pass over the
// allocations, a pass over the free table to find its neighbors, two decision
// states and an update pass. A refused allocate and a free of an unknown
// address skip the rest after their first decision state, a free refused for
// a full free table answers after its second decision state, and a zero-size
// allocate answers without any pass. Each of these waits while the previous
// result still sits in the output register. One request is in work at a
// time; a finished result sits in an output register, so the next request
// can be accepted while it waits to be taken. The heap base register is
// written over its own channel and must only be written while no request is
// in work. PAGE_BYTES must be a power of two. No clearing pass is needed
// after reset.
module best_fit_page_allocator_top #(
  parameter int unsigned PAGE_BYTES  = 4096,
  parameter int unsigned HEAP_PAGES  = 131072,
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bfpa_pkg::bfpa_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bfpa_pkg::bfpa_rsp_t out_data_o
);

  import bfpa_pkg::*;

`include "best_fit_page_allocator_top_defines.svh"

  localparam int unsigned N        = MAX_EXTENTS;
  localparam int unsigned IW       = $clog2(N);
  localparam int unsigned CW       = $clog2(N + 1);
  localparam int unsigned SW       = $clog2(HEAP_PAGES);
  localparam int unsigned LW       = $clog2(HEAP_PAGES + 1);
  localparam int unsigned PB_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned NW       = 31 - PB_SHIFT;
  localparam int unsigned CMPW     = (LW > NW) ? LW : NW;
  localparam logic [LW-1:0] HEAP_LEN = LW'(HEAP_PAGES);

  // Byte address of a heap page under the current base, modulo 2^32.
  function automatic logic [31:0] page_addr(logic [SW-1:0] pg, logic [31:0] base);
    return base + (32'(pg) << PB_SHIFT);
  endfunction

  // Tail views of both rings and the values written back at their heads.
  logic          f_tail_v, f_nxt_v, u_tail_v;
  logic [SW-1:0] f_tail_s, f_nxt_s, u_tail_s;
  logic [LW-1:0] f_tail_l, f_nxt_l, u_tail_l;
  logic          f_w_v, u_w_v;
  logic [SW-1:0] f_w_s, u_w_s;
  logic [LW-1:0] f_w_l, u_w_l;

  bfpa_state_e   state_q, state_d;
  logic          shift;
  logic          last_step;
  logic          accept;
  logic          resp_load;

  logic [31:0]   heap_base_q;
  bfpa_kind_e    op_q;
  logic [NW-1:0] need_q;
  logic [31:0]   va_q;
  logic [IW-1:0] t_q;
  logic [CW-1:0] free_cnt_q, used_cnt_q;

  // Captured by the scan passes.
  logic          found_q;
  logic [IW-1:0] idx_q;
  logic [SW-1:0] s_q;
  logic [LW-1:0] len_q;
  logic [SW-1:0] last_s_q;
  logic [LW-1:0] last_l_q;
  logic          predv_q, nxtv_q;
  logic [SW-1:0] pred_s_q, nxt_s_q;
  logic [LW-1:0] pred_l_q, nxt_l_q;
  logic [CW-1:0] p_q;

  // Plan for the update pass.
  logic          fmod_en_q, fdel_en_q, fins_en_q, uwr_en_q, uinv_en_q;
  logic [IW-1:0] fmod_idx_q, fdel_idx_q, fins_idx_q, uwr_idx_q, uinv_idx_q;
  logic [SW-1:0] fmod_s_q, uwr_s_q;
  logic [LW-1:0] fmod_l_q, uwr_l_q;
  logic          hold_v_q;
  logic [SW-1:0] hold_s_q;
  logic [LW-1:0] hold_l_q;

  bfpa_status_e  res_status_q;
  logic [31:0]   res_addr_q;
  logic [17:0]   res_pages_q;
  logic          out_valid_q;
  bfpa_rsp_t     out_data_q;

  logic [30:0]   round_sum;
  logic [NW-1:0] need_in;
  logic          fit_hit, used_hit, left, right, free_full, used_full;

  bfpa_chain #(
    .DEPTH(N), .SW(SW), .LW(LW), .TAIL_VALID(1'b1), .TAIL_LEN(HEAP_LEN)
  ) u_free_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_i      (shift),
    .valid_i      (f_w_v),
    .start_i      (f_w_s),
    .len_i        (f_w_l),
    .tail_valid_o (f_tail_v),
    .tail_start_o (f_tail_s),
    .tail_len_o   (f_tail_l),
    .nxt_valid_o  (f_nxt_v),
    .nxt_start_o  (f_nxt_s),
    .nxt_len_o    (f_nxt_l)
  );

  bfpa_chain #(
    .DEPTH(N), .SW(SW), .LW(LW), .TAIL_VALID(1'b0), .TAIL_LEN('0)
  ) u_used_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_i      (shift),
    .valid_i      (u_w_v),
    .start_i      (u_w_s),
    .len_i        (u_w_l),
    .tail_valid_o (u_tail_v),
    .tail_start_o (u_tail_s),
    .tail_len_o   (u_tail_l),
    .nxt_valid_o  (),
    .nxt_start_o  (),
    .nxt_len_o    ()
  );

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign last_step   = (t_q == IW'(N - 1));
  assign resp_load   = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  // Page count of an allocate, rounded up.
  assign round_sum = 31'(in_data_i.request_bytes) + 31'(PAGE_BYTES - 1);
  assign need_in   = round_sum[30:PB_SHIFT];

  // A free extent fits when it holds the request and beats the best so far;
  // the strict compare keeps the lowest address among equal sizes.
  assign fit_hit  = f_tail_v && (CMPW'(f_tail_l) >= CMPW'(need_q)) &&
                    (!found_q || (f_tail_l < len_q));
  assign used_hit = u_tail_v && !found_q && (page_addr(u_tail_s, heap_base_q) == va_q);

  // Neighbor tests of the extent being freed.
  assign left  = predv_q && ((LW+1)'(pred_s_q) + (LW+1)'(pred_l_q) == (LW+1)'(s_q));
  assign right = nxtv_q && ((LW+1)'(s_q) + (LW+1)'(len_q) == (LW+1)'(nxt_s_q));
  assign free_full = (free_cnt_q == CW'(N));
  assign used_full = (used_cnt_q == CW'(N));

  always_comb begin
    state_d = state_q;
    shift   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.kind == KIND_FREE) begin
            state_d = ST_USED_SCAN;
          end else if (in_data_i.request_bytes == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_FIT_SCAN;
          end
        end
      end
      ST_FIT_SCAN: begin
        shift = 1'b1;
        if (last_step) state_d = ST_FIT_CHECK;
      end
      ST_FIT_CHECK: begin
        state_d = (found_q && !used_full) ? ST_UPDATE : ST_RESP;
      end
      ST_USED_SCAN: begin
        shift = 1'b1;
        if (last_step) state_d = ST_USED_CHECK;
      end
      ST_USED_CHECK: begin
        state_d = found_q ? ST_HOLE_SCAN : ST_RESP;
      end
      ST_HOLE_SCAN: begin
        shift = 1'b1;
        if (last_step) state_d = ST_HOLE_CHECK;
      end
      ST_HOLE_CHECK: begin
        state_d = (!left && !right && free_full) ? ST_RESP : ST_UPDATE;
      end
      ST_UPDATE: begin
        shift = 1'b1;
        if (last_step) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Free ring write-back. After an insert point the stream lags by one entry
  // through the hold register; after a delete point it reads one cell ahead.
  always_comb begin
    f_w_v = f_tail_v;
    f_w_s = f_tail_s;
    f_w_l = f_tail_l;
    if (state_q == ST_UPDATE) begin
      if (fins_en_q && (t_q >= fins_idx_q)) begin
        if (t_q == fins_idx_q) begin
          f_w_v = 1'b1;
          f_w_s = s_q;
          f_w_l = len_q;
        end else begin
          f_w_v = hold_v_q;
          f_w_s = hold_s_q;
          f_w_l = hold_l_q;
        end
      end else if (fdel_en_q && (t_q >= fdel_idx_q)) begin
        f_w_v = last_step ? 1'b0 : f_nxt_v;
        f_w_s = f_nxt_s;
        f_w_l = f_nxt_l;
      end else if (fmod_en_q && (t_q == fmod_idx_q)) begin
        f_w_v = 1'b1;
        f_w_s = fmod_s_q;
        f_w_l = fmod_l_q;
      end
    end
  end

  // Allocation ring write-back: append, or move the last entry into the hole.
  always_comb begin
    u_w_v = u_tail_v;
    u_w_s = u_tail_s;
    u_w_l = u_tail_l;
    if (state_q == ST_UPDATE) begin
      if (uinv_en_q && (t_q == uinv_idx_q)) begin
        u_w_v = 1'b0;
      end else if (uwr_en_q && (t_q == uwr_idx_q)) begin
        u_w_v = 1'b1;
        u_w_s = uwr_s_q;
        u_w_l = uwr_l_q;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      heap_base_q <= HEAP_BASE_RESET;
      free_cnt_q  <= CW'(1);
      used_cnt_q  <= '0;
      t_q         <= '0;
      found_q     <= 1'b0;
      predv_q     <= 1'b0;
      nxtv_q      <= 1'b0;
      hold_v_q    <= 1'b0;
      fmod_en_q   <= 1'b0;
      fdel_en_q   <= 1'b0;
      fins_en_q   <= 1'b0;
      uwr_en_q    <= 1'b0;
      uinv_en_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) heap_base_q <= cfg_data_i;
      if (shift) t_q <= last_step ? '0 : t_q + 1'b1;
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        found_q   <= 1'b0;
        predv_q   <= 1'b0;
        nxtv_q    <= 1'b0;
        fmod_en_q <= 1'b0;
        fdel_en_q <= 1'b0;
        fins_en_q <= 1'b0;
        uwr_en_q  <= 1'b0;
        uinv_en_q <= 1'b0;
      end
      unique case (state_q)
        ST_FIT_SCAN: begin
          if (fit_hit) found_q <= 1'b1;
        end
        ST_USED_SCAN: begin
          if (used_hit) found_q <= 1'b1;
        end
        ST_HOLE_SCAN: begin
          if (f_tail_v && (f_tail_s <= s_q)) predv_q <= 1'b1;
          if (f_tail_v && (f_tail_s > s_q)) nxtv_q <= 1'b1;
        end
        ST_FIT_CHECK: begin
          if (found_q && !used_full) begin
            uwr_en_q   <= 1'b1;
            used_cnt_q <= used_cnt_q + 1'b1;
            if (len_q == LW'(need_q)) begin
              fdel_en_q  <= 1'b1;
              free_cnt_q <= free_cnt_q - 1'b1;
            end else begin
              fmod_en_q <= 1'b1;
            end
          end
        end
        ST_HOLE_CHECK: begin
          if (left || right || !free_full) begin
            uwr_en_q   <= 1'b1;
            uinv_en_q  <= 1'b1;
            used_cnt_q <= used_cnt_q - 1'b1;
            if (left && right) begin
              fmod_en_q  <= 1'b1;
              fdel_en_q  <= 1'b1;
              free_cnt_q <= free_cnt_q - 1'b1;
            end else if (left || right) begin
              fmod_en_q <= 1'b1;
            end else begin
              fins_en_q  <= 1'b1;
              free_cnt_q <= free_cnt_q + 1'b1;
            end
          end
        end
        ST_UPDATE: begin
          if (fins_en_q && (t_q >= fins_idx_q)) hold_v_q <= f_tail_v;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= in_data_i.kind;
      need_q       <= need_in;
      va_q         <= in_data_i.release_address & ~32'(PAGE_BYTES - 1);
      p_q          <= '0;
      res_status_q <= STATUS_ZERO;
      res_addr_q   <= '0;
      res_pages_q  <= '0;
    end
    if (resp_load) out_data_q <= '{res_status_q, res_addr_q, res_pages_q};
    unique case (state_q)
      ST_FIT_SCAN: begin
        if (fit_hit) begin
          idx_q <= t_q;
          s_q   <= f_tail_s;
          len_q <= f_tail_l;
        end
      end
      ST_USED_SCAN: begin
        if (used_hit) begin
          idx_q <= t_q;
          s_q   <= u_tail_s;
          len_q <= u_tail_l;
        end
        // Entries are packed, so the last valid one seen is the table's end.
        if (u_tail_v) begin
          last_s_q <= u_tail_s;
          last_l_q <= u_tail_l;
        end
      end
      ST_HOLE_SCAN: begin
        if (f_tail_v && (f_tail_s <= s_q)) begin
          pred_s_q <= f_tail_s;
          pred_l_q <= f_tail_l;
          p_q      <= CW'(t_q) + 1'b1;
        end
        if (f_tail_v && (f_tail_s > s_q) && !nxtv_q) begin
          nxt_s_q <= f_tail_s;
          nxt_l_q <= f_tail_l;
        end
      end
      ST_FIT_CHECK: begin
        fmod_idx_q <= idx_q;
        fdel_idx_q <= idx_q;
        fmod_s_q   <= s_q + SW'(need_q);
        fmod_l_q   <= len_q - LW'(need_q);
        uwr_idx_q  <= IW'(used_cnt_q);
        uwr_s_q    <= s_q;
        uwr_l_q    <= LW'(need_q);
        if (!found_q) begin
          res_status_q <= STATUS_NO_FIT;
        end else if (used_full) begin
          res_status_q <= STATUS_FULL;
        end else begin
          res_status_q <= STATUS_OK;
          res_addr_q   <= page_addr(s_q, heap_base_q);
          res_pages_q  <= 18'(need_q);
        end
      end
      ST_USED_CHECK: begin
        if (!found_q) res_status_q <= STATUS_NOT_ALLOC;
      end
      ST_HOLE_CHECK: begin
        uwr_idx_q  <= idx_q;
        uwr_s_q    <= last_s_q;
        uwr_l_q    <= last_l_q;
        uinv_idx_q <= IW'(used_cnt_q - 1'b1);
        fdel_idx_q <= IW'(p_q);
        fins_idx_q <= IW'(p_q);
        if (left) begin
          fmod_idx_q <= IW'(p_q - 1'b1);
          fmod_s_q   <= pred_s_q;
          fmod_l_q   <= right ? (pred_l_q + len_q + nxt_l_q) : (pred_l_q + len_q);
        end else begin
          fmod_idx_q <= IW'(p_q);
          fmod_s_q   <= s_q;
          fmod_l_q   <= len_q + nxt_l_q;
        end
        if (!left && !right && free_full) begin
          res_status_q <= STATUS_FULL;
        end else begin
          res_status_q <= STATUS_OK;
          res_addr_q   <= page_addr(s_q, heap_base_q);
          res_pages_q  <= 18'(len_q);
        end
      end
      ST_UPDATE: begin
        if (fins_en_q && (t_q >= fins_idx_q)) begin
          hold_s_q <= f_tail_s;
          hold_l_q <= f_tail_l;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Between requests each ring is aligned, so its tail is table entry zero.
  `BFPA_ASSERT(a_free_aligned, (state_q != ST_IDLE) || (f_tail_v == (free_cnt_q != '0)), "free table misaligned")
  `BFPA_ASSERT(a_used_aligned, (state_q != ST_IDLE) || (u_tail_v == (used_cnt_q != '0)), "allocation table misaligned")
  `BFPA_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE, "accepted request did not start")
  `BFPA_ASSERT(a_plan_excl, !(fins_en_q && fdel_en_q) || (op_q == KIND_ALLOC && !fins_en_q), "insert and delete planned together")

endmodule

/* test/bfpa_checker.sv */
// Checker that predicts and compares every result of the best-fit page allocator.
module bfpa_checker
  import bfpa_pkg::*;
#(
  parameter int unsigned PAGE_BYTES  = 4096,
  parameter int unsigned HEAP_PAGES  = 131072,
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  bfpa_req_t   in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  bfpa_rsp_t   out_data_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  logic [31:0] heap_base;
  int unsigned hole_start [MAX_EXTENTS];
  int unsigned hole_len   [MAX_EXTENTS];
  int unsigned hole_cnt;
  int unsigned grant_start[MAX_EXTENTS];
  int unsigned grant_len  [MAX_EXTENTS];
  int unsigned grant_cnt;
  bfpa_rsp_t   awaited_q[$];
  int          mismatches;

  function automatic logic [31:0] page_address(int unsigned pg);
    return heap_base + 32'(longint'(pg) * PAGE_BYTES);
  endfunction

  function automatic void drop_hole(int unsigned i);
    for (int unsigned k = i; k + 1 < hole_cnt; k++) begin
      hole_start[k] = hole_start[k + 1];
      hole_len[k]   = hole_len[k + 1];
    end
    if (hole_cnt > 0) hole_cnt--;
  endfunction

  function automatic bfpa_rsp_t carve_pages(logic [29:0] bytes);
    bfpa_rsp_t   rsp;
    longint      need;
    int unsigned best;
    int unsigned first;
    bit          found;
    rsp   = '0;
    best  = 0;
    found = 0;
    if (bytes == 0) begin
      rsp.status = STATUS_ZERO;
      return rsp;
    end
    need = (longint'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
    for (int unsigned i = 0; i < hole_cnt; i++) begin
      if (hole_len[i] >= need && (!found || hole_len[i] < hole_len[best])) begin
        best  = i;
        found = 1;
      end
    end
    if (!found) begin
      rsp.status = STATUS_NO_FIT;
      return rsp;
    end
    if (grant_cnt >= MAX_EXTENTS) begin
      rsp.status = STATUS_FULL;
      return rsp;
    end
    first = hole_start[best];
    if (hole_len[best] == need) drop_hole(best);
    else begin
      hole_start[best] = first + int'(need);
      hole_len[best]   = hole_len[best] - int'(need);
    end
    grant_start[grant_cnt] = first;
    grant_len[grant_cnt]   = int'(need);
    grant_cnt++;
    rsp.status          = STATUS_OK;
    rsp.granted_address = page_address(first);
    rsp.page_count      = 18'(need);
    return rsp;
  endfunction

  function automatic bfpa_rsp_t return_pages(logic [31:0] addr);
    bfpa_rsp_t   rsp;
    logic [31:0] va;
    int unsigned u, s, len, p;
    bit          found, merge_lo, merge_hi;
    rsp   = '0;
    u     = 0;
    found = 0;
    va    = addr - (addr % PAGE_BYTES);
    for (int unsigned i = 0; i < grant_cnt; i++) begin
      if (!found && page_address(grant_start[i]) == va) begin
        u     = i;
        found = 1;
      end
    end
    if (!found) begin
      rsp.status = STATUS_NOT_ALLOC;
      return rsp;
    end
    s   = grant_start[u];
    len = grant_len[u];
    p   = 0;
    while (p < hole_cnt && hole_start[p] <= s) p++;
    merge_lo = p > 0 && longint'(hole_start[p - 1]) + hole_len[p - 1] == s;
    merge_hi = p < hole_cnt && longint'(s) + len == hole_start[p];
    if (!merge_lo && !merge_hi && hole_cnt >= MAX_EXTENTS) begin
      rsp.status = STATUS_FULL;
      return rsp;
    end
    grant_cnt--;
    grant_start[u] = grant_start[grant_cnt];
    grant_len[u]   = grant_len[grant_cnt];
    if (merge_lo && merge_hi) begin
      hole_len[p - 1] = hole_len[p - 1] + len + hole_len[p];
      drop_hole(p);
    end else if (merge_lo) begin
      hole_len[p - 1] = hole_len[p - 1] + len;
    end else if (merge_hi) begin
      hole_start[p] = s;
      hole_len[p]   = hole_len[p] + len;
    end else begin
      for (int unsigned k = hole_cnt; k > p; k--) begin
        hole_start[k] = hole_start[k - 1];
        hole_len[k]   = hole_len[k - 1];
      end
      hole_start[p] = s;
      hole_len[p]   = len;
      hole_cnt++;
    end
    rsp.status          = STATUS_OK;
    rsp.granted_address = page_address(s);
    rsp.page_count      = 18'(len);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bfpa_rsp_t want;
    if (!rst_ni) begin
      heap_base = HEAP_BASE_RESET;
      for (int i = 0; i < MAX_EXTENTS; i++) begin
        hole_start[i] = 0;
        hole_len[i]   = 0;
      end
      hole_len[0] = HEAP_PAGES;
      hole_cnt    = 1;
      grant_cnt   = 0;
      awaited_q.delete();
      mismatches  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) heap_base = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind == KIND_ALLOC) awaited_q.push_back(carve_pages(in_data_i.request_bytes));
        else awaited_q.push_back(return_pages(in_data_i.release_address));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          $error("result transaction with no request waiting");
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          if (out_data_i.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_data_i.status);
            mismatches++;
          end
          if (out_data_i.granted_address !== want.granted_address) begin
            $error("granted_address expected %h got %h", want.granted_address,
                   out_data_i.granted_address);
            mismatches++;
          end
          if (out_data_i.page_count !== want.page_count) begin
            $error("page_count expected %0d got %0d", want.page_count, out_data_i.page_count);
            mismatches++;
          end
        end
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= awaited_q.size();
  end

endmodule

/* test/tb.sv */
// Testbench top of the best-fit page allocator: stimulus, pacing and verdict.
module tb;
  import bfpa_pkg::*;

  localparam int unsigned PAGE_BYTES     = 4096;
  localparam int unsigned HEAP_PAGES     = 131072;
  localparam int unsigned MAX_EXTENTS    = 64;
  // A free takes about three passes over a table; leave generous room.
  localparam int unsigned DRAIN_CYCLES   = 3 * MAX_EXTENTS + 20;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned PHASE_ITEMS    = 205;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  bfpa_req_t   in_data;
  logic        out_valid;
  logic        out_ready;
  bfpa_rsp_t   out_data;
  int          mismatches;
  int          outstanding;

  // Bookkeeping for each request transaction, so that the result can tell us
  // which heap offsets are live and may be released later.
  typedef struct {
    bfpa_kind_e  kind;
    bit          tracked;
    logic [31:0] offset;
  } issued_t;

  issued_t     issued_q[$];
  logic [31:0] live_offsets[$];
  logic [31:0] heap_base_now;
  bit          track_nb;
  logic [31:0] offset_nb;
  int          rsp_count;
  bfpa_rsp_t   last_rsp;
  int          gap_pct;
  int          stall_pct;
  int          idle_cycles;
  int          n_sent, n_alloc_ok, n_free_ok, n_refused;

  best_fit_page_allocator_top #(
    .PAGE_BYTES (PAGE_BYTES),
    .HEAP_PAGES (HEAP_PAGES),
    .MAX_EXTENTS(MAX_EXTENTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  bfpa_checker #(
    .PAGE_BYTES (PAGE_BYTES),
    .HEAP_PAGES (HEAP_PAGES),
    .MAX_EXTENTS(MAX_EXTENTS)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The receiver drops ready at random while a stall percentage is set.
  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= stall_pct);

  // Track results, keep the list of live allocations and run the watchdog.
  always @(posedge clk_i) begin
    issued_t done;
    if (rst_ni) begin
      if (in_valid && in_ready) issued_q.push_back('{in_data.kind, track_nb, offset_nb});
      if (out_valid && out_ready && issued_q.size() > 0) begin
        done = issued_q.pop_front();
        rsp_count <= rsp_count + 1;
        last_rsp  <= out_data;
        if (out_data.status == STATUS_OK) begin
          if (done.kind == KIND_ALLOC) begin
            live_offsets.push_back(out_data.granted_address - heap_base_now);
            n_alloc_ok++;
          end else n_free_ok++;
        end else begin
          n_refused++;
          // A release refused for a full free table leaves the allocation live.
          if (done.kind == KIND_FREE && done.tracked && out_data.status == STATUS_FULL)
            live_offsets.push_back(done.offset);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Hands one request transaction to the block. Valid stays high after the
  // handshake, so back-to-back requests never lower and raise it in one step.
  task automatic send(input bfpa_req_t req, input bit tracked, input logic [31:0] off);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_data   <= req;
    track_nb  <= tracked;
    offset_nb <= off;
    do @(posedge clk_i); while (!in_ready);
    n_sent++;
  endtask

  task automatic idle_in();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one request and waits for its own result.
  task automatic transact(input bfpa_req_t req, input bit tracked, input logic [31:0] off);
    int seen;
    seen = rsp_count;
    send(req, tracked, off);
    idle_in();
    while (rsp_count == seen) @(posedge clk_i);
  endtask

  function automatic bfpa_req_t alloc_req(logic [29:0] bytes);
    bfpa_req_t r;
    r.kind            = KIND_ALLOC;
    r.request_bytes   = bytes;
    r.release_address = $urandom;
    return r;
  endfunction

  function automatic bfpa_req_t free_req(logic [31:0] addr);
    bfpa_req_t r;
    r.kind            = KIND_FREE;
    r.request_bytes   = $urandom;
    r.release_address = addr;
    return r;
  endfunction

  // Address of a live allocation, with random bits below the page boundary.
  function automatic logic [31:0] live_address(logic [31:0] off);
    return heap_base_now + off + $urandom_range(PAGE_BYTES - 1);
  endfunction

  // The base register is only written once every result has come back.
  task automatic set_base(input logic [31:0] value);
    idle_in();
    while (outstanding != 0) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    heap_base_now  = value;
    @(posedge clk_i);
  endtask

  task automatic release_live(input int idx, input bit wait_rsp);
    logic [31:0] off;
    off = live_offsets[idx];
    live_offsets.delete(idx);
    if (wait_rsp) transact(free_req(live_address(off)), 1'b1, off);
    else send(free_req(live_address(off)), 1'b1, off);
  endtask

  // Fragments the heap: rounds of same-size allocations until the used table
  // is full, then every other block of the round is released. Each round uses
  // a larger size so the holes are never refilled, which drives the free table
  // to its capacity and makes a release bounce off it.
  task automatic fragment_heap();
    int first;
    for (int k = 1; k <= 7; k++) begin
      first = live_offsets.size();
      for (int n = 0; n <= MAX_EXTENTS; n++) begin
        transact(alloc_req(30'(k * PAGE_BYTES)), 1'b0, '0);
        if (last_rsp.status != STATUS_OK) break;
      end
      for (int i = live_offsets.size() - 1; i >= first; i -= 2) release_live(i, 1'b1);
    end
    for (int n = 0; n < 4 * MAX_EXTENTS && live_offsets.size() > 0; n++) release_live(0, 1'b1);
  endtask

  task automatic random_item(input bit filling);
    bfpa_req_t r;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // Noise: every field fully random, half of them releases of mostly unknown pages.
      r.kind            = bfpa_kind_e'($urandom_range(1));
      r.request_bytes   = $urandom;
      r.release_address = $urandom;
      send(r, 1'b0, '0);
    end else if (pick < 9) begin
      case ($urandom_range(3))
        0:       send(alloc_req('0), 1'b0, '0);
        1:       send(alloc_req(30'h3FFF_FFFF), 1'b0, '0);
        2:       send(alloc_req(30'(HEAP_PAGES * PAGE_BYTES)), 1'b0, '0);
        default: send(alloc_req(30'($urandom_range(1, HEAP_PAGES * PAGE_BYTES / 4))), 1'b0, '0);
      endcase
    end else if (live_offsets.size() > 0 && $urandom_range(99) < (filling ? 30 : 70)) begin
      release_live($urandom_range(live_offsets.size() - 1), 1'b0);
    end else begin
      pick = $urandom_range(99);
      if (pick < 80) send(alloc_req(30'($urandom_range(1, 4 * PAGE_BYTES))), 1'b0, '0);
      else if (pick < 97) send(alloc_req(30'($urandom_range(1, 64 * PAGE_BYTES))), 1'b0, '0);
      else send(alloc_req(30'($urandom_range(1, HEAP_PAGES * PAGE_BYTES / 2))), 1'b0, '0);
    end
  endtask

  initial begin
    logic [31:0] bases[4];
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    track_nb      = 1'b0;
    offset_nb     = '0;
    rsp_count     = 0;
    last_rsp      = '0;
    gap_pct       = 0;
    stall_pct     = 0;
    idle_cycles   = 0;
    n_sent        = 0;
    n_alloc_ok    = 0;
    n_free_ok     = 0;
    n_refused     = 0;
    heap_base_now = HEAP_BASE_RESET;
    bases         = '{32'h0000_0000, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'h1234_5000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset base. The whole heap goes in one grant,
    // then nothing else fits; after its release the same address is unknown.
    transact(alloc_req(30'(HEAP_PAGES * PAGE_BYTES)), 1'b0, '0);
    transact(alloc_req(30'd1), 1'b0, '0);
    transact(free_req(heap_base_now + 32'd123), 1'b0, '0);
    transact(free_req(heap_base_now), 1'b0, '0);
    transact(alloc_req('0), 1'b0, '0);
    transact(alloc_req(30'h3FFF_FFFF), 1'b0, '0);
    // Three small grants: pages 0, 1 and 2..3. Releasing page 1 makes a lone
    // hole, then 2..3 merges on both sides, then page 0 merges to the right.
    transact(alloc_req(30'd1), 1'b0, '0);
    transact(alloc_req(30'(PAGE_BYTES)), 1'b0, '0);
    transact(alloc_req(30'(PAGE_BYTES + 1)), 1'b0, '0);
    transact(free_req(heap_base_now + PAGE_BYTES), 1'b0, '0);
    transact(free_req(heap_base_now + 2 * PAGE_BYTES + 32'hFFF), 1'b0, '0);
    transact(free_req(heap_base_now), 1'b0, '0);
    // An exact fit empties the free table; the second release then lands at
    // the tail and must merge with its predecessor.
    transact(alloc_req(30'(PAGE_BYTES)), 1'b0, '0);
    transact(alloc_req(30'((HEAP_PAGES - 1) * PAGE_BYTES)), 1'b0, '0);
    transact(free_req(heap_base_now), 1'b0, '0);
    transact(free_req(heap_base_now + PAGE_BYTES), 1'b0, '0);
    transact(free_req(32'hFFFF_FFFF), 1'b0, '0);
    transact(free_req(32'h0000_0000), 1'b0, '0);

    // Full used table, full free table, then a clean heap again.
    fragment_heap();

    // Random phases, each under its own base and pacing. Filling and draining
    // alternate so the tables keep swinging between empty and full.
    for (int ph = 0; ph < 4; ph++) begin
      set_base(bases[ph]);
      gap_pct   = (ph == 1) ? 49 : (ph == 3) ? 8 : 0;
      stall_pct = (ph == 2) ? 49 : (ph == 3) ? 8 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) random_item(((n / 50) % 2) == 0);
    end

    idle_in();
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d grants, %0d releases, %0d refused.",
             n_sent, n_alloc_ok, n_free_ok, n_refused);
    $display("Covered five heap bases, a fragmented heap and four pacing modes.");
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* best_fit_page_allocator_top.f */
+incdir+design
design/bfpa_pkg.sv
design/bfpa_cell.sv
design/bfpa_chain.sv
design/best_fit_page_allocator_top.sv
test/bfpa_checker.sv
test/tb.sv
